[rtl/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// Cross blur filter package
// Shared widths, register indexes, result types and the arithmetic helpers
// used by the cross blur filter modules.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int CHAN_W = 8;
    localparam int PIX_W = 3 * CHAN_W;
    localparam int SUM_W = 11;

    localparam int CFG_WIDTH_W = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_WIDTH_W-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam int CBF_MAX_WIDTH = 2048;
    localparam int CBF_MAX_HEIGHT = 4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PUSH_MAX = 3;
    localparam int PUSH_W = 2;

    // Division by five as a multiply by 3277 / 2^14, exact for sums below 2^14.
    localparam int DIV5_MUL_W = 12;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 12'd3277;
    localparam int DIV5_SHIFT = 14;
    localparam int PROD_W = SUM_W + DIV5_MUL_W;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } cbf_sums_t;

    typedef struct packed {
        cbf_sums_t sums;
        logic      last_of_run;
        logic      frame_done;
    } cbf_entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cbf_cell_ctrl_t;

    typedef struct packed {
        logic y_ge1;
        logic y_is0;
        logic y_is1;
        logic x_is0;
        logic x_is1;
        logic lastc;
        logic lastr;
        logic fwd_c;
        logic fwd_r;
    } cbf_flags_t;

    function automatic cbf_sums_t sum5(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] u,
        input logic [PIX_W-1:0] l,
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] d
    );
        cbf_sums_t s;
        s.red = SUM_W'(c[2*CHAN_W +: CHAN_W]) + SUM_W'(u[2*CHAN_W +: CHAN_W])
              + SUM_W'(l[2*CHAN_W +: CHAN_W]) + SUM_W'(r[2*CHAN_W +: CHAN_W])
              + SUM_W'(d[2*CHAN_W +: CHAN_W]);
        s.green = SUM_W'(c[CHAN_W +: CHAN_W]) + SUM_W'(u[CHAN_W +: CHAN_W])
                + SUM_W'(l[CHAN_W +: CHAN_W]) + SUM_W'(r[CHAN_W +: CHAN_W])
                + SUM_W'(d[CHAN_W +: CHAN_W]);
        s.blue = SUM_W'(c[0 +: CHAN_W]) + SUM_W'(u[0 +: CHAN_W])
               + SUM_W'(l[0 +: CHAN_W]) + SUM_W'(r[0 +: CHAN_W])
               + SUM_W'(d[0 +: CHAN_W]);
        return s;
    endfunction

    function automatic logic [CHAN_W-1:0] div5(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(DIV5_MUL);
        return prod[DIV5_SHIFT +: CHAN_W];
    endfunction

endpackage

[rtl/cbf_cell.sv]
// ----------------------------------------------------------------------------
// Cross blur filter result cell
// One slot of the result chain. It loads a new result or takes the contents
// of its neighbor further from the head when the head result is taken.
// ----------------------------------------------------------------------------
module cbf_cell
    import cbf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cbf_cell_ctrl_t ctrl,
    input  cbf_entry_t     load_entry,
    input  logic           nbr_valid,
    input  cbf_entry_t     nbr_entry,
    output logic           cell_valid,
    output cbf_entry_t     cell_entry
);

    logic       valid_reg;
    cbf_entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= nbr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= nbr_entry;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_entry = entry_reg;

endmodule

[rtl/cbf_out_queue.sv]
// ----------------------------------------------------------------------------
// Cross blur filter result chain
// A row of result cells that collapses toward the head. Up to three results
// enter per cycle behind the occupied cells, and the head drives the output.
// ----------------------------------------------------------------------------
module cbf_out_queue
    import cbf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [PUSH_W-1:0]      push_n,
    input  cbf_entry_t             push_data [PUSH_MAX],
    input  logic                   out_stall,
    output logic                   head_valid,
    output cbf_entry_t             head_entry,
    output logic [QUEUE_CNT_W-1:0] free_slots
);

    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic [QUEUE_CNT_W-1:0] base;
    logic                   pop;

    logic           cell_valid [QUEUE_DEPTH];
    cbf_entry_t     cell_entry [QUEUE_DEPTH];
    cbf_cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];
    cbf_entry_t     cell_load  [QUEUE_DEPTH];
    logic           nbr_valid  [QUEUE_DEPTH];
    cbf_entry_t     nbr_entry  [QUEUE_DEPTH];

    assign pop = cell_valid[0] && !out_stall;
    assign base = count_reg - QUEUE_CNT_W'(pop);
    assign count_next = base + QUEUE_CNT_W'(push_n);
    assign free_slots = QUEUE_CNT_W'(QUEUE_DEPTH) - count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [QUEUE_CNT_W-1:0] offset;

        assign offset = QUEUE_CNT_W'(i) - base;

        always_comb
        begin
            cell_ctrl[i].shift = pop;
            cell_ctrl[i].load = (QUEUE_CNT_W'(i) >= base)
                             && (offset < QUEUE_CNT_W'(push_n));
            if (offset == QUEUE_CNT_W'(0))
            begin
                cell_load[i] = push_data[0];
            end
            else if (offset == QUEUE_CNT_W'(1))
            begin
                cell_load[i] = push_data[1];
            end
            else
            begin
                cell_load[i] = push_data[2];
            end
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign nbr_valid[i] = 1'b0;
            assign nbr_entry[i] = '0;
        end
        else
        begin : g_body
            assign nbr_valid[i] = cell_valid[i+1];
            assign nbr_entry[i] = cell_entry[i+1];
        end

        cbf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[i]),
            .load_entry (cell_load[i]),
            .nbr_valid  (nbr_valid[i]),
            .nbr_entry  (nbr_entry[i]),
            .cell_valid (cell_valid[i]),
            .cell_entry (cell_entry[i])
        );
    end

    assign head_valid = cell_valid[0];
    assign head_entry = cell_entry[0];

endmodule

[rtl/cbf_line_stores.sv]
// ----------------------------------------------------------------------------
// Cross blur filter line stores
// The previous row and the row before it. The previous row is read at the
// current and the next column; all read data is registered.
// ----------------------------------------------------------------------------
module cbf_line_stores
    import cbf_pkg::*;
#(
    parameter int MAX_WIDTH = CBF_MAX_WIDTH
)(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_c,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_r,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [PIX_W-1:0]             wr_prior,
    input  logic [PIX_W-1:0]             wr_second,
    output logic [PIX_W-1:0]             rd_prior_c,
    output logic [PIX_W-1:0]             rd_prior_r,
    output logic [PIX_W-1:0]             rd_second
);

    logic [PIX_W-1:0] prior_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] second_mem [MAX_WIDTH];

    logic [PIX_W-1:0] rd_prior_c_reg;
    logic [PIX_W-1:0] rd_prior_r_reg;
    logic [PIX_W-1:0] rd_second_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prior_mem[wr_addr] <= wr_prior;
        end
        if (rd_en)
        begin
            rd_prior_c_reg <= prior_mem[rd_addr_c];
            rd_prior_r_reg <= prior_mem[rd_addr_r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            second_mem[wr_addr] <= wr_second;
        end
        if (rd_en)
        begin
            rd_second_reg <= second_mem[rd_addr_c];
        end
    end

    assign rd_prior_c = rd_prior_c_reg;
    assign rd_prior_r = rd_prior_r_reg;
    assign rd_second = rd_second_reg;

endmodule

[rtl/cross_blur_filter.sv]
// ----------------------------------------------------------------------------
// Cross blur filter
// Five-point cross blur of a raster-order RGB stream with clamped edges.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock through most of the frame when
// the output is not stalled and returns the blurred pixel one row later, via
// the request register and the result chain, after the request completing
// its neighborhood. In the last row each request past the first column
// produces two results (three at the last column); the output moves one
// result per cycle, so the input waits on it, and the four-entry result chain
// sets how much is absorbed. A stalled output stops the input once the chain
// lacks room for the next results. The line stores need no clearing pass.
// ----------------------------------------------------------------------------
module cross_blur_filter
    import cbf_pkg::*;
#(
    parameter int MAX_WIDTH = CBF_MAX_WIDTH,
    parameter int MAX_HEIGHT = CBF_MAX_HEIGHT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CHAN_W-1:0]      red_in,
    input  logic [CHAN_W-1:0]      green_in,
    input  logic [CHAN_W-1:0]      blue_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAN_W-1:0]      red_out,
    output logic [CHAN_W-1:0]      green_out,
    output logic [CHAN_W-1:0]      blue_out,
    output logic                   last_of_run,
    output logic                   frame_done
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCW = (XW + 1 > CFG_WIDTH_W) ? XW + 1 : CFG_WIDTH_W;
    localparam int HCW = (YW + 1 > CFG_HEIGHT_W) ? YW + 1 : CFG_HEIGHT_W;

    logic [CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [CFG_HEIGHT_W-1:0] frame_height_reg;

    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_reg;
    logic [YW-1:0] row_next;

    logic [WCW-1:0] fw_ext;
    logic [WCW-1:0] w_eff;
    logic [WCW-1:0] x_plus1;
    logic [HCW-1:0] fh_ext;
    logic [HCW-1:0] h_eff;
    logic [HCW-1:0] y_plus1;
    logic           lastc0;
    logic           lastr0;
    logic           accept;
    logic [XW-1:0]  rd_addr_r;
    cbf_flags_t     flags0;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [XW-1:0]    s1_x_reg;
    cbf_flags_t       s1_flags_reg;
    logic [PIX_W-1:0] fwd_px_reg;
    logic [PIX_W-1:0] fwd_p_reg;

    logic [PIX_W-1:0] win0_reg;
    logic [PIX_W-1:0] win1_reg;
    logic [PIX_W-1:0] win2_reg;

    logic [PIX_W-1:0] rd_prior_c;
    logic [PIX_W-1:0] rd_prior_r;
    logic [PIX_W-1:0] rd_second;
    logic [PIX_W-1:0] p1;
    logic [PIX_W-1:0] s1;
    logic [PIX_W-1:0] rnb;

    logic       has_a;
    logic       has_b;
    logic       has_c;
    cbf_entry_t res_a;
    cbf_entry_t res_b;
    cbf_entry_t res_c;
    cbf_entry_t push_data [PUSH_MAX];
    logic [PUSH_W-1:0] n1;
    logic [PUSH_W-1:0] push_n;
    logic              retire;

    logic [QUEUE_CNT_W-1:0] free_slots;
    logic                   head_valid;
    cbf_entry_t             head_entry;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[CFG_WIDTH_W-1:0];
                end
                REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request position and edge flags.
    always_comb
    begin
        fw_ext = WCW'(frame_width_reg);
        if (fw_ext == '0)
        begin
            w_eff = WCW'(1);
        end
        else if (fw_ext > WCW'(MAX_WIDTH))
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end

        fh_ext = HCW'(frame_height_reg);
        if (fh_ext == '0)
        begin
            h_eff = HCW'(1);
        end
        else if (fh_ext > HCW'(MAX_HEIGHT))
        begin
            h_eff = HCW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = fh_ext;
        end

        x_plus1 = WCW'(col_reg) + WCW'(1);
        y_plus1 = HCW'(row_reg) + HCW'(1);
        lastc0 = (x_plus1 >= w_eff);
        lastr0 = (y_plus1 >= h_eff);

        rd_addr_r = lastc0 ? col_reg : col_reg + XW'(1);

        flags0.y_ge1 = (row_reg != '0);
        flags0.y_is0 = (row_reg == '0);
        flags0.y_is1 = (row_reg == YW'(1));
        flags0.x_is0 = (col_reg == '0);
        flags0.x_is1 = (col_reg == XW'(1));
        flags0.lastc = lastc0;
        flags0.lastr = lastr0;
        flags0.fwd_c = s1_valid_reg && (s1_x_reg == col_reg);
        flags0.fwd_r = s1_valid_reg && (s1_x_reg == rd_addr_r);

        if (lastc0)
        begin
            col_next = '0;
            row_next = lastr0 ? '0 : y_plus1[YW-1:0];
        end
        else
        begin
            col_next = x_plus1[XW-1:0];
            row_next = row_reg;
        end
    end

    assign accept = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // The request in flight writes its column when it retires, which may be the
    // same edge at which the next request reads the stores.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg <= {red_in, green_in, blue_in};
            s1_x_reg <= col_reg;
            s1_flags_reg <= flags0;
            fwd_px_reg <= s1_px_reg;
            fwd_p_reg <= p1;
        end
    end

    cbf_line_stores #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_stores (
        .clk        (clk),
        .rd_en      (accept),
        .rd_addr_c  (col_reg),
        .rd_addr_r  (rd_addr_r),
        .wr_en      (retire),
        .wr_addr    (s1_x_reg),
        .wr_prior   (s1_px_reg),
        .wr_second  (p1),
        .rd_prior_c (rd_prior_c),
        .rd_prior_r (rd_prior_r),
        .rd_second  (rd_second)
    );

    assign p1 = s1_flags_reg.fwd_c ? fwd_px_reg : rd_prior_c;
    assign s1 = s1_flags_reg.fwd_c ? fwd_p_reg : rd_second;
    assign rnb = s1_flags_reg.fwd_r ? fwd_px_reg : rd_prior_r;

    // Results of the request in flight, in delivery order.
    always_comb
    begin
        has_a = s1_flags_reg.y_ge1;
        has_b = s1_flags_reg.lastr && !s1_flags_reg.x_is0;
        has_c = s1_flags_reg.lastr && s1_flags_reg.lastc;

        res_a.sums = sum5(p1,
                          s1_flags_reg.y_is1 ? p1 : s1,
                          s1_flags_reg.x_is0 ? p1 : win2_reg,
                          s1_flags_reg.lastc ? p1 : rnb,
                          s1_px_reg);
        res_a.last_of_run = !has_b && !has_c;
        res_a.frame_done = 1'b0;

        res_b.sums = sum5(win0_reg,
                          s1_flags_reg.y_is0 ? win0_reg : win2_reg,
                          s1_flags_reg.x_is1 ? win0_reg : win1_reg,
                          s1_px_reg,
                          win0_reg);
        res_b.last_of_run = !has_c;
        res_b.frame_done = 1'b0;

        res_c.sums = sum5(s1_px_reg,
                          s1_flags_reg.y_is0 ? s1_px_reg : p1,
                          s1_flags_reg.x_is0 ? s1_px_reg : win0_reg,
                          s1_px_reg,
                          s1_px_reg);
        res_c.last_of_run = 1'b1;
        res_c.frame_done = 1'b1;

        push_data[0] = has_a ? res_a : (has_b ? res_b : res_c);
        push_data[1] = (has_a && has_b) ? res_b : res_c;
        push_data[2] = res_c;

        n1 = PUSH_W'(has_a) + PUSH_W'(has_b) + PUSH_W'(has_c);
    end

    assign retire = s1_valid_reg && (QUEUE_CNT_W'(n1) <= free_slots);
    assign push_n = retire ? n1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
        end
        else if (retire)
        begin
            win1_reg <= win0_reg;
            win0_reg <= s1_px_reg;
            win2_reg <= p1;
        end
    end

    cbf_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_data  (push_data),
        .out_stall  (out_stall),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .free_slots (free_slots)
    );

    assign out_valid = head_valid;
    assign red_out = div5(head_entry.sums.red);
    assign green_out = div5(head_entry.sums.green);
    assign blue_out = div5(head_entry.sums.blue);
    assign last_of_run = head_entry.last_of_run;
    assign frame_done = head_entry.frame_done;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Cross blur filter testbench
// Streams RGB frames through the cross blur filter. Each accepted pixel
// request is run through a local line-store model that predicts the blurred
// pixels it releases. Every returned pixel is checked field by field, in
// order, against that prediction. The run covers small hand-built frames,
// the reset frame size, mid-frame size reductions, the size extremes, random
// frames under several idle and stall mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb
    import cbf_pkg::*;
();

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_of_run;
        logic              frame_done;
    } blur_pixel_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [CHAN_W-1:0]      red_in;
    logic [CHAN_W-1:0]      green_in;
    logic [CHAN_W-1:0]      blue_in;
    logic                   out_valid;
    logic                   out_stall;
    logic [CHAN_W-1:0]      red_out;
    logic [CHAN_W-1:0]      green_out;
    logic [CHAN_W-1:0]      blue_out;
    logic                   last_of_run;
    logic                   frame_done;

    // Local copy of the filter state: frame size, the two previous rows,
    // the recent pixels of the current row and the raster position.
    logic [CFG_WIDTH_W-1:0]  cfg_width;
    logic [CFG_HEIGHT_W-1:0] cfg_height;
    logic [PIX_W-1:0]        line_above [0:CBF_MAX_WIDTH-1];
    logic [PIX_W-1:0]        line_above2 [0:CBF_MAX_WIDTH-1];
    logic [PIX_W-1:0]        left1;
    logic [PIX_W-1:0]        left2;
    logic [PIX_W-1:0]        above_left;
    int                      col_pos;
    int                      row_pos;

    blur_pixel_t blurred_q [$];
    blur_pixel_t head;
    int          mismatches;
    int          sent_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_cycles;

    cross_blur_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .last_of_run(last_of_run),
        .frame_done (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [CHAN_W-1:0] avg5(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [CHAN_W-1:0] c,
                                               input logic [CHAN_W-1:0] d,
                                               input logic [CHAN_W-1:0] e);
        return CHAN_W'((int'(a) + int'(b) + int'(c) + int'(d) + int'(e)) / 5);
    endfunction

    function automatic blur_pixel_t blur_cross(input logic [PIX_W-1:0] c,
                                               input logic [PIX_W-1:0] u,
                                               input logic [PIX_W-1:0] l,
                                               input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] d,
                                               input logic done);
        blur_pixel_t b;
        b.red = avg5(c[23:16], u[23:16], l[23:16], r[23:16], d[23:16]);
        b.green = avg5(c[15:8], u[15:8], l[15:8], r[15:8], d[15:8]);
        b.blue = avg5(c[7:0], u[7:0], l[7:0], r[7:0], d[7:0]);
        b.last_of_run = 1'b0;
        b.frame_done = done;
        return b;
    endfunction

    // Outputs lag by one row; the last row also releases its own pixels.
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int w;
        int h;
        int x;
        int y;
        int n;
        logic lastc;
        logic lastr;
        logic [PIX_W-1:0] p;
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] c;
        blur_pixel_t res [3];
        w = (cfg_width == 0) ? 1 : ((cfg_width > CBF_MAX_WIDTH) ? CBF_MAX_WIDTH : cfg_width);
        h = (cfg_height == 0) ? 1
            : ((cfg_height > CBF_MAX_HEIGHT) ? CBF_MAX_HEIGHT : cfg_height);
        x = (col_pos >= CBF_MAX_WIDTH) ? CBF_MAX_WIDTH - 1 : col_pos;
        y = row_pos;
        n = 0;
        lastc = (x + 1 >= w);
        lastr = (y + 1 >= h);
        p = line_above[x];
        s = line_above2[x];
        if (y >= 1)
        begin
            res[n] = blur_cross(p, (y == 1) ? p : s, (x == 0) ? p : above_left,
                                lastc ? p : line_above[x + 1], px, 1'b0);
            n++;
        end
        if (lastr && x >= 1)
        begin
            c = left1;
            res[n] = blur_cross(c, (y == 0) ? c : above_left, (x == 1) ? c : left2,
                                px, c, 1'b0);
            n++;
        end
        if (lastr && lastc)
        begin
            res[n] = blur_cross(px, (y == 0) ? px : p, (x == 0) ? px : left1,
                                px, px, 1'b1);
            n++;
        end
        if (n > 0)
            res[n - 1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++)
            blurred_q.push_back(res[k]);
        line_above2[x] = p;
        line_above[x] = px;
        left2 = left1;
        left1 = px;
        above_left = p;
        if (lastc)
        begin
            col_pos = 0;
            row_pos = lastr ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in <= px[23:16];
        green_in <= px[15:8];
        blue_in <= px[7:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pixel(px);
        sent_count++;
    endtask

    // Sends random pixels until the raster position wraps to a new frame.
    task automatic send_frame();
        send_pixel(PIX_W'($urandom));
        while (col_pos != 0 || row_pos != 0)
            send_pixel(PIX_W'($urandom));
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            cfg_width = CFG_WIDTH_W'(value);
        else
            cfg_height = CFG_HEIGHT_W'(value);
    endtask

    task automatic set_frame(input int w, input int h);
        wait_until_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Part of a row is sent at the reset size; the frame is then cut to four by two.
    task automatic test_reset_size();
        repeat (10) send_pixel(PIX_W'($urandom));
        wait_until_idle();
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 2);
        send_frame();
    endtask

    task automatic test_tiny_frames();
        set_frame(1, 1);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        set_frame(2, 2);
        send_pixel(24'hFF0000);
        send_pixel(24'h00FF00);
        send_pixel(24'h0000FF);
        send_pixel(24'hFFFFFF);
        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? 24'h0180FE : (i[0] ? 24'hFFFFFF : 24'h000000));
        set_frame(3, 2);
        repeat (6) send_pixel(24'hFFFFFF);
    endtask

    // Shrinking the frame mid-way makes the current column or row the last.
    task automatic test_mid_frame_shrink();
        set_frame(8, 4);
        repeat (13) send_pixel(PIX_W'($urandom));
        wait_until_idle();
        write_reg(REG_FRAME_WIDTH, 4);
        send_frame();
        set_frame(4, 8);
        repeat (20) send_pixel(PIX_W'($urandom));
        wait_until_idle();
        write_reg(REG_FRAME_HEIGHT, 3);
        send_frame();
    endtask

    // Oversized settings act as the largest frame until a later cut ends it; zero settings act as one.
    task automatic test_size_extremes();
        set_frame(13'h1FFF, 1);
        repeat (20) send_pixel(PIX_W'($urandom));
        wait_until_idle();
        write_reg(REG_FRAME_WIDTH, 3);
        send_frame();
        set_frame(1, 13'h1FFF);
        repeat (6) send_pixel(PIX_W'($urandom));
        wait_until_idle();
        write_reg(REG_FRAME_HEIGHT, 2);
        send_frame();
        set_frame(0, 3);
        send_frame();
        set_frame(5, 0);
        send_frame();
    endtask

    task automatic test_random_frames();
        int idle_mix [4];
        int stall_mix [4];
        int start;
        int w;
        int h;
        idle_mix = '{0, 87, 0, 38};
        stall_mix = '{0, 0, 87, 38};
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_mix[phase];
            stall_pct = stall_mix[phase];
            start = sent_count;
            while (sent_count - start < 35)
            begin
                w = ($urandom_range(7) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
                h = $urandom_range(6, 1);
                set_frame(w, h);
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(w * h - 1)) send_pixel(PIX_W'($urandom));
                    wait_until_idle();
                    if ($urandom_range(1) == 0)
                        write_reg(REG_FRAME_WIDTH, $urandom_range(w, 1));
                    else
                        write_reg(REG_FRAME_HEIGHT, $urandom_range(h, 1));
                end
                send_frame();
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // The output is held off long enough for the result chain to fill.
    task automatic test_output_holdoff();
        set_frame(8, 3);
        hold_cycles = 150;
        send_frame();
        set_frame(6, 2);
        hold_cycles = 80;
        send_frame();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= (hold_cycles > 0) || ($urandom_range(99) < stall_pct);
            if (hold_cycles > 0)
                hold_cycles--;
        end
    end

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (blurred_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h %h %h %b %b",
                         $time, red_out, green_out, blue_out, last_of_run, frame_done);
                mismatches++;
            end
            else
            begin
                head = blurred_q.pop_front();
                check_field("red_out", head.red, red_out);
                check_field("green_out", head.green, green_out);
                check_field("blue_out", head.blue, blue_out);
                check_field("last_of_run", CHAN_W'(head.last_of_run),
                            CHAN_W'(last_of_run));
                check_field("frame_done", CHAN_W'(head.frame_done), CHAN_W'(frame_done));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        sent_count = 0;
        cfg_width = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
        for (int i = 0; i < CBF_MAX_WIDTH; i++)
        begin
            line_above[i] = '0;
            line_above2[i] = '0;
        end
        left1 = '0;
        left2 = '0;
        above_left = '0;
        col_pos = 0;
        row_pos = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_tiny_frames();
        test_mid_frame_shrink();
        test_size_extremes();
        test_random_frames();
        test_output_holdoff();
        wait_until_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
